// File: rtl/l4thp_pkg.sv
`default_nettype none

package l4thp_pkg;

  // frame limits
  localparam int MaxFrameBytes = 16383;
  localparam int PortBytes     = 4;

  // ethertypes and protocols
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [15:0] EtherVlan = 16'h8100;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [5:0]  MinIpHdr  = 6'd20;
  localparam logic [5:0]  MinTcpHdr = 6'd20;
  localparam logic [5:0]  UdpHdr    = 6'd8;
  localparam logic [3:0]  MinTagBytes = 4'd3;

  // fixed byte positions of the ethertype low byte and l3 start, field offsets
  localparam int EtherPos0 = 13;
  localparam int EtherPos1 = 17;
  localparam int EtherPos2 = 21;
  localparam logic [4:0] L3Off0 = 5'd14;
  localparam logic [4:0] L3Off1 = 5'd18;
  localparam logic [4:0] L3Off2 = 5'd22;
  localparam logic [4:0] ProtoPos = 5'd9;
  localparam logic [4:0] TcpOffPos = 5'd12;

  // status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoIpv4  = 2'd1;
  localparam logic [1:0] StatusBadIp   = 2'd2;
  localparam logic [1:0] StatusNoL4    = 2'd3;

  // tunnel kinds
  localparam logic [1:0] TunnelNone = 2'd0;
  localparam logic [1:0] TunnelData = 2'd1;
  localparam logic [1:0] TunnelFrag = 2'd2;

  // configuration register indexes
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 8;
  localparam logic [CfgIndexWidth-1:0] RegNonceBytes   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegTunnelBytes  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegDataMagic    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegFragMagic    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegFragTagBytes = 3'd4;

  // configuration reset values
  localparam logic [4:0] NonceBytesReset   = 5'd12;
  localparam logic [5:0] TunnelBytesReset  = 6'd14;
  localparam logic [7:0] DataMagicReset    = 8'd0;
  localparam logic [7:0] FragMagicReset    = 8'd1;
  localparam logic [3:0] FragTagBytesReset = 4'd4;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  l3_offset;
    logic [5:0]  ip_header_length;
    logic [7:0]  ip_protocol;
    logic [6:0]  transport_offset;
    logic [5:0]  transport_header_length;
    logic [1:0]  tunnel_kind;
    logic [15:0] fragment_packet_id;
    logic [7:0]  fragment_index;
    logic [13:0] frame_length;
    logic [13:0] payload_length;
  } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/l4_tunnel_header_parser_unit.sv
`default_nettype none

// l4 tunnel header parser
//
// in channel: one frame byte per beat (packet_byte, last_byte), valid/stall.
// out channel: one classification beat per frame, sent after the beat that
// carries last_byte; nothing is sent for the other bytes of the frame.
// cfg channel: valid/ready register writes (cfg_index, cfg_data); ready is
// always high, writes are meant to land only between frames.
//
// output: registered; the result is on out_valid in the cycle after the last
// byte is taken. throughput: one byte per cycle while not stalled; every byte
// updates position counter and a few capture registers combinationally.
// stalls: the single output register holds a result until the receiver
// takes it; bytes that do not end a frame keep flowing meanwhile, and only
// a last byte is held off (in_stall) while an untaken result still sits in
// the output register.
// reset: rst (synchronous) clears the frame state, drops out_valid and
// returns all configuration registers to their defaults.
// frames longer than MAX_FRAME_BYTES stop counting and capturing at that size.
module l4_tunnel_header_parser_unit #(
  parameter int MAX_FRAME_BYTES = l4thp_pkg::MaxFrameBytes
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  l4thp_pkg::in_beat_t                      in_data,
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output l4thp_pkg::out_beat_t                     out_data,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire  [l4thp_pkg::CfgIndexWidth-1:0]      cfg_index,
  input  wire  [l4thp_pkg::CfgDataWidth-1:0]       cfg_data
);
  import l4thp_pkg::*;

  // position counter width follows the frame size limit
  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

  // configuration registers
  logic [4:0] nonce_bytes;
  logic [5:0] tunnel_header_bytes;
  logic [7:0] data_tunnel_magic;
  logic [7:0] fragment_tunnel_magic;
  logic [3:0] fragment_tag_bytes;

  // per-frame state
  logic [PW-1:0] byte_position;
  logic [15:0]   ethertype_shift;
  logic [4:0]    found_l3_offset;
  logic [1:0]    vlan_tags;
  logic [3:0]    ihl_nibble;
  logic [7:0]    protocol_byte;
  logic [3:0]    tcp_offset_nibble;
  logic          tunnel_first_msb;
  logic [7:0]    tunnel_magic_seen;
  logic [15:0]   frag_id_capture;
  logic [7:0]    frag_index_capture;

  logic [PW-1:0] byte_position_next;
  logic [15:0]   ethertype_shift_next;
  logic [4:0]    found_l3_offset_next;
  logic [1:0]    vlan_tags_next;
  logic [3:0]    ihl_nibble_next;
  logic [7:0]    protocol_byte_next;
  logic [3:0]    tcp_offset_nibble_next;
  logic          tunnel_first_msb_next;
  logic [7:0]    tunnel_magic_seen_next;
  logic [15:0]   frag_id_capture_next;
  logic [7:0]    frag_index_capture_next;

  logic       in_accept;
  logic       take;
  logic [7:0] b;
  logic [PW-1:0] idx;
  logic       l3_known;

  // capture positions for the current byte
  logic [6:0] cap_l4;
  logic [6:0] cap_tun;
  logic [7:0] cap_tag;
  logic [7:0] cap_magic;

  out_beat_t result;

  assign cfg_ready = 1'b1;

  // only a last byte can collide with a result still waiting
  assign in_stall  = out_valid && out_stall && in_valid && in_data.last_byte;
  assign in_accept = in_valid && !in_stall;

  assign b    = in_data.packet_byte;
  assign idx  = byte_position;
  assign take = byte_position < PW'(MAX_FRAME_BYTES);

  // per-byte state update
  always_comb begin
    byte_position_next      = byte_position;
    ethertype_shift_next    = ethertype_shift;
    found_l3_offset_next    = found_l3_offset;
    vlan_tags_next          = vlan_tags;
    ihl_nibble_next         = ihl_nibble;
    protocol_byte_next      = protocol_byte;
    tcp_offset_nibble_next  = tcp_offset_nibble;
    tunnel_first_msb_next   = tunnel_first_msb;
    tunnel_magic_seen_next  = tunnel_magic_seen;
    frag_id_capture_next    = frag_id_capture;
    frag_index_capture_next = frag_index_capture;
    l3_known                = 1'b0;
    cap_l4                  = 7'(found_l3_offset) + {1'b0, ihl_nibble, 2'b00};
    cap_tun                 = cap_l4 + 7'(PortBytes);
    cap_tag                 = 8'(cap_tun) + 8'(tunnel_header_bytes);
    cap_magic               = 8'(cap_tun) + 8'(nonce_bytes) + 8'd1;
    if (take) begin
      byte_position_next   = byte_position + 1'b1;
      ethertype_shift_next = {ethertype_shift[7:0], b};
      // ethertype search behind up to two vlan tags
      if (idx == PW'(EtherPos0)) begin
        if (ethertype_shift_next == EtherIpv4) begin
          found_l3_offset_next = L3Off0;
        end else if (ethertype_shift_next == EtherVlan) begin
          vlan_tags_next = 2'd1;
        end
      end else if (idx == PW'(EtherPos1) && vlan_tags == 2'd1 &&
                   found_l3_offset == '0) begin
        if (ethertype_shift_next == EtherIpv4) begin
          found_l3_offset_next = L3Off1;
        end else if (ethertype_shift_next == EtherVlan) begin
          vlan_tags_next = 2'd2;
        end
      end else if (idx == PW'(EtherPos2) && vlan_tags == 2'd2 &&
                   found_l3_offset == '0) begin
        if (ethertype_shift_next == EtherIpv4) begin
          found_l3_offset_next = L3Off2;
        end
      end
      l3_known = found_l3_offset_next != '0;
      cap_l4   = 7'(found_l3_offset_next) + {1'b0, ihl_nibble, 2'b00};
      cap_tun  = cap_l4 + 7'(PortBytes);
      cap_tag  = 8'(cap_tun) + 8'(tunnel_header_bytes);
      cap_magic = 8'(cap_tun) + 8'(nonce_bytes) + 8'd1;
      if (l3_known) begin
        if (idx == PW'(found_l3_offset_next)) begin
          ihl_nibble_next = b[3:0];
        end else begin
          if (idx == PW'(found_l3_offset_next) + PW'(ProtoPos)) begin
            protocol_byte_next = b;
          end
          if (idx > PW'(found_l3_offset_next)) begin
            if (idx == PW'(cap_l4) + PW'(TcpOffPos)) begin
              tcp_offset_nibble_next = b[7:4];
            end
            if (idx == PW'(cap_tun)) begin
              tunnel_first_msb_next = b[7];
            end
            if (idx == PW'(cap_magic)) begin
              tunnel_magic_seen_next = b;
            end
            if (idx == PW'(cap_tag)) begin
              frag_id_capture_next[15:8] = b;
            end
            if (idx == PW'(cap_tag) + PW'(1)) begin
              frag_id_capture_next[7:0] = b;
            end
            if (idx == PW'(cap_tag) + PW'(2)) begin
              frag_index_capture_next = b;
            end
          end
        end
      end
    end
  end

  // classification of the finished frame, from the state after this byte
  logic [PW-1:0] len;
  logic [5:0]    hl;
  logic [6:0]    toff;
  logic [6:0]    tun;
  logic [7:0]    magic_pos;
  logic [7:0]    tun_end;
  logic [3:0]    tagn;
  logic [7:0]    tag_end;
  logic [PW-1:0] rem;
  logic [PW-1:0] pay;
  logic [5:0]    tcp_len;
  logic          magic_ok;
  logic [1:0]    status;

  always_comb begin
    len       = byte_position_next;
    hl        = {ihl_nibble_next, 2'b00};
    toff      = 7'(found_l3_offset_next) + 7'(hl);
    tun       = toff + 7'(PortBytes);
    magic_pos = 8'(tun) + 8'(nonce_bytes) + 8'd1;
    tun_end   = 8'(tun) + 8'(tunnel_header_bytes);
    tagn      = (fragment_tag_bytes < MinTagBytes) ? MinTagBytes : fragment_tag_bytes;
    tag_end   = tun_end + 8'(tagn);
    rem       = (len > PW'(toff)) ? len - PW'(toff) : '0;
    pay       = (len > PW'(tun)) ? len - PW'(tun) : '0;
    tcp_len   = {tcp_offset_nibble_next, 2'b00};
    magic_ok  = len > PW'(magic_pos);

    if (found_l3_offset_next == '0) begin
      status = StatusNoIpv4;
    end else if (len < PW'(found_l3_offset_next) + PW'(MinIpHdr)) begin
      status = StatusBadIp;
    end else if (protocol_byte_next != ProtoTcp && protocol_byte_next != ProtoUdp) begin
      status = StatusNoL4;
    end else if (hl < MinIpHdr) begin
      status = StatusBadIp;
    end else begin
      status = StatusOk;
    end

    result                         = '0;
    result.status                  = status;
    result.frame_length            = 14'(len);
    if (status != StatusNoIpv4) begin
      result.l3_offset        = found_l3_offset_next;
      result.ip_header_length = hl;
      result.ip_protocol      = protocol_byte_next;
    end
    if (status == StatusOk) begin
      result.transport_offset = toff;
      result.payload_length   = 14'(pay);
      if (protocol_byte_next == ProtoTcp) begin
        if (rem >= PW'(MinTcpHdr) && tcp_len >= MinTcpHdr && PW'(tcp_len) <= rem) begin
          result.transport_header_length = tcp_len;
        end
      end else if (rem >= PW'(UdpHdr)) begin
        result.transport_header_length = UdpHdr;
      end
      // data tunnel wins when both match
      if (len >= PW'(tun_end) && magic_ok &&
          tunnel_magic_seen_next == data_tunnel_magic && !tunnel_first_msb_next) begin
        result.tunnel_kind = TunnelData;
      end else if (len >= PW'(tag_end) && magic_ok &&
                   tunnel_magic_seen_next == fragment_tunnel_magic) begin
        result.tunnel_kind        = TunnelFrag;
        result.fragment_packet_id = frag_id_capture_next;
        result.fragment_index     = frag_index_capture_next;
      end
    end
  end

  // frame state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst || (in_accept && in_data.last_byte)) begin
      byte_position      <= '0;
      ethertype_shift    <= '0;
      found_l3_offset    <= '0;
      vlan_tags          <= '0;
      ihl_nibble         <= '0;
      protocol_byte      <= '0;
      tcp_offset_nibble  <= '0;
      tunnel_first_msb   <= 1'b0;
      tunnel_magic_seen  <= '0;
      frag_id_capture    <= '0;
      frag_index_capture <= '0;
    end else if (in_accept) begin
      byte_position      <= byte_position_next;
      ethertype_shift    <= ethertype_shift_next;
      found_l3_offset    <= found_l3_offset_next;
      vlan_tags          <= vlan_tags_next;
      ihl_nibble         <= ihl_nibble_next;
      protocol_byte      <= protocol_byte_next;
      tcp_offset_nibble  <= tcp_offset_nibble_next;
      tunnel_first_msb   <= tunnel_first_msb_next;
      tunnel_magic_seen  <= tunnel_magic_seen_next;
      frag_id_capture    <= frag_id_capture_next;
      frag_index_capture <= frag_index_capture_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_byte) begin
      out_data <= result;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nonce_bytes           <= NonceBytesReset;
      tunnel_header_bytes   <= TunnelBytesReset;
      data_tunnel_magic     <= DataMagicReset;
      fragment_tunnel_magic <= FragMagicReset;
      fragment_tag_bytes    <= FragTagBytesReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegNonceBytes: begin
          nonce_bytes <= cfg_data[4:0];
        end
        RegTunnelBytes: begin
          tunnel_header_bytes <= cfg_data[5:0];
        end
        RegDataMagic: begin
          data_tunnel_magic <= cfg_data;
        end
        RegFragMagic: begin
          fragment_tunnel_magic <= cfg_data;
        end
        RegFragTagBytes: begin
          fragment_tag_bytes <= cfg_data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/l4thp_checker.sv
`default_nettype none

module l4thp_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_stall,
  input l4thp_pkg::in_beat_t  in_data,
  input wire                  out_valid,
  input wire                  out_stall,
  input l4thp_pkg::out_beat_t out_data
);
  import l4thp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // every accepted last byte yields a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last_byte |=> out_valid)
    else $error("no result after last byte");

  // a taken result is not repeated without a new last byte
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(in_valid && !in_stall && in_data.last_byte)
    |=> !out_valid)
    else $error("result repeated");

  // failed frames carry no transport or tunnel info
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != StatusOk |->
      out_data.tunnel_kind == TunnelNone && out_data.transport_header_length == '0 &&
      out_data.payload_length == '0 && out_data.transport_offset == '0)
    else $error("failed frame carries transport fields");

  // fragment fields only with a fragment tunnel
  a_frag_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tunnel_kind != TunnelFrag |->
      out_data.fragment_packet_id == '0 && out_data.fragment_index == '0)
    else $error("fragment fields without fragment tunnel");

endmodule

bind l4_tunnel_header_parser_unit l4thp_checker u_l4thp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/l4_tunnel_header_parser_unit_tb.sv
`default_nettype none

module l4_tunnel_header_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import l4thp_pkg::*;

  // run limits
  localparam int CycleLimit     = 2000000;
  localparam int DrainCycles    = 8;
  localparam int LongHoldCycles = 400;
  localparam int FrameBufBytes  = 16400;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // block ports, all inputs driven to known values from time zero
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_beat_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_beat_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;

  l4_tunnel_header_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // byte beats waiting to be offered, and classifications still owed by the block
  in_beat_t  pending_bytes[$];
  out_beat_t predicted_classes[$];

  // knobs set by the stimulus thread, read by driver and receiver
  int idle_pct    = 0;
  bit quiet       = 1'b0;
  bit hold_armed  = 1'b0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycles         = 0;

  // ---------------------------------------------------------------------------
  // predictor: own copy of the configuration and of the per-frame capture state
  // ---------------------------------------------------------------------------
  logic [4:0]  nonce_len    = NonceBytesReset;
  logic [5:0]  tun_hdr_len  = TunnelBytesReset;
  logic [7:0]  data_magic   = DataMagicReset;
  logic [7:0]  frag_magic   = FragMagicReset;
  logic [3:0]  tag_len      = FragTagBytesReset;

  logic [13:0] pos_cnt      = '0;
  logic [15:0] et_shift     = '0;
  logic [4:0]  l3_found     = '0;
  logic [1:0]  vlan_cnt     = '0;
  logic [3:0]  ihl_cap      = '0;
  logic [7:0]  proto_cap    = '0;
  logic [3:0]  doff_cap     = '0;
  logic        first_msb    = 1'b0;
  logic [7:0]  magic_cap    = '0;
  logic [15:0] frag_id_cap  = '0;
  logic [7:0]  frag_idx_cap = '0;

  task automatic clear_frame_state();
    pos_cnt      = '0;
    et_shift     = '0;
    l3_found     = '0;
    vlan_cnt     = '0;
    ihl_cap      = '0;
    proto_cap    = '0;
    doff_cap     = '0;
    first_msb    = 1'b0;
    magic_cap    = '0;
    frag_id_cap  = '0;
    frag_idx_cap = '0;
  endtask

  task automatic apply_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    case (idx)
      RegNonceBytes:   nonce_len   = val[4:0];
      RegTunnelBytes:  tun_hdr_len = val[5:0];
      RegDataMagic:    data_magic  = val;
      RegFragMagic:    frag_magic  = val;
      RegFragTagBytes: tag_len     = val[3:0];
      default: ;
    endcase
  endtask

  // one accepted byte beat; the closing beat queues the frame's classification
  task automatic classify_byte(input in_beat_t beat);
    int        idx, t, tun, tag, len, hl, rem, d, magic_pos, tagn;
    out_beat_t res;
    idx = int'(pos_cnt);
    if (idx < MaxFrameBytes) begin
      et_shift = {et_shift[7:0], beat.packet_byte};
      if (idx == EtherPos0) begin
        if (et_shift == EtherIpv4) l3_found = L3Off0;
        else if (et_shift == EtherVlan) vlan_cnt = 2'd1;
      end else if (idx == EtherPos1 && vlan_cnt == 2'd1 && l3_found == 0) begin
        if (et_shift == EtherIpv4) l3_found = L3Off1;
        else if (et_shift == EtherVlan) vlan_cnt = 2'd2;
      end else if (idx == EtherPos2 && vlan_cnt == 2'd2 && l3_found == 0) begin
        if (et_shift == EtherIpv4) l3_found = L3Off2;
      end
      if (l3_found != 0) begin
        if (idx == int'(l3_found)) begin
          ihl_cap = beat.packet_byte[3:0];
        end else begin
          if (idx == int'(l3_found) + int'(ProtoPos)) proto_cap = beat.packet_byte;
          if (idx > int'(l3_found)) begin
            t   = int'(l3_found) + 4 * int'(ihl_cap);
            tun = t + PortBytes;
            tag = tun + int'(tun_hdr_len);
            if (idx == t + int'(TcpOffPos)) doff_cap = beat.packet_byte[7:4];
            if (idx == tun) first_msb = beat.packet_byte[7];
            if (idx == tun + int'(nonce_len) + 1) magic_cap = beat.packet_byte;
            if (idx == tag) frag_id_cap[15:8] = beat.packet_byte;
            if (idx == tag + 1) frag_id_cap[7:0] = beat.packet_byte;
            if (idx == tag + 2) frag_idx_cap = beat.packet_byte;
          end
        end
      end
      pos_cnt = pos_cnt + 14'd1;
    end
    if (beat.last_byte) begin
      len = int'(pos_cnt);
      res = '0;
      res.frame_length = 14'(len);
      if (l3_found == 0) begin
        res.status = StatusNoIpv4;
      end else begin
        hl = 4 * int'(ihl_cap);
        res.l3_offset        = l3_found;
        res.ip_header_length = 6'(hl);
        res.ip_protocol      = proto_cap;
        if (len < int'(l3_found) + int'(MinIpHdr)) res.status = StatusBadIp;
        else if (proto_cap != ProtoTcp && proto_cap != ProtoUdp) res.status = StatusNoL4;
        else if (hl < int'(MinIpHdr)) res.status = StatusBadIp;
        else res.status = StatusOk;
        if (res.status == StatusOk) begin
          t = int'(l3_found) + hl;
          res.transport_offset = 7'(t);
          rem = (len > t) ? len - t : 0;
          if (proto_cap == ProtoTcp) begin
            d = 4 * int'(doff_cap);
            if (rem >= int'(MinTcpHdr) && d >= int'(MinTcpHdr) && d <= rem)
              res.transport_header_length = 6'(d);
          end else if (rem >= int'(UdpHdr)) begin
            res.transport_header_length = UdpHdr;
          end
          tun = t + PortBytes;
          res.payload_length = 14'((len > tun) ? len - tun : 0);
          magic_pos = tun + int'(nonce_len) + 1;
          tagn = (tag_len < MinTagBytes) ? int'(MinTagBytes) : int'(tag_len);
          // data tunnel wins when both magics match
          if (len >= tun + int'(tun_hdr_len) && len > magic_pos &&
              magic_cap == data_magic && !first_msb) begin
            res.tunnel_kind = TunnelData;
          end else if (len >= tun + int'(tun_hdr_len) + tagn && len > magic_pos &&
                       magic_cap == frag_magic) begin
            res.tunnel_kind        = TunnelFrag;
            res.fragment_packet_id = frag_id_cap;
            res.fragment_index     = frag_idx_cap;
          end
        end
      end
      predicted_classes.push_back(res);
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d, %s: got %0d, expected %0d",
             results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic cmp_field(input string name, input int got, input int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  task automatic check_class(input out_beat_t got);
    out_beat_t want;
    if (predicted_classes.size() == 0) begin
      report_mismatch("result beat with nothing owed", 1, 0);
    end else begin
      want = predicted_classes.pop_front();
      cmp_field("status", got.status, want.status);
      cmp_field("l3_offset", got.l3_offset, want.l3_offset);
      cmp_field("ip_header_length", got.ip_header_length, want.ip_header_length);
      cmp_field("ip_protocol", got.ip_protocol, want.ip_protocol);
      cmp_field("transport_offset", got.transport_offset, want.transport_offset);
      cmp_field("transport_header_length", got.transport_header_length,
                want.transport_header_length);
      cmp_field("tunnel_kind", got.tunnel_kind, want.tunnel_kind);
      cmp_field("fragment_packet_id", got.fragment_packet_id, want.fragment_packet_id);
      cmp_field("fragment_index", got.fragment_index, want.fragment_index);
      cmp_field("frame_length", got.frame_length, want.frame_length);
      cmp_field("payload_length", got.payload_length, want.payload_length);
    end
    results_seen++;
  endtask

  // monitor: register writes, accepted byte beats and accepted result beats,
  // in that order, all sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_frame_state();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) classify_byte(in_data);
      if (out_valid && !out_stall) check_class(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // driver: byte beats from the pending queue, with random idle bursts
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      // previous beat taken (or none offered): pick what goes out next
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet && idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
        // idle burst: in_valid drops and send_gap is loaded with a random value
        in_valid <= 1'b0;
        send_gap <= $urandom_range(16, 0);
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  int recv_gap  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LongHoldCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      out_stall <= 1'b1;
      recv_gap  <= $urandom_range(16, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results owed", cycles,
               predicted_classes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: frame builder and register writes
  // ---------------------------------------------------------------------------
  logic [7:0] frame_buf [0:FrameBufBytes-1];
  int         frame_len = 0;

  // what the stimulus side last wrote, used to place tunnel fields
  int         stim_nonce      = NonceBytesReset;
  int         stim_tun_hdr    = TunnelBytesReset;
  logic [7:0] stim_data_magic = DataMagicReset;
  logic [7:0] stim_frag_magic = FragMagicReset;
  int         stim_tag        = FragTagBytesReset;

  task automatic fill_frame(input int len);
    for (int i = 0; i < len; i++) frame_buf[i] = 8'($urandom);
    frame_len = len;
  endtask

  task automatic put_byte(input int p, input logic [7:0] v);
    if (p < frame_len) frame_buf[p] = v;
  endtask

  task automatic push_frame();
    in_beat_t beat;
    for (int i = 0; i < frame_len; i++) begin
      beat.packet_byte = frame_buf[i];
      beat.last_byte   = (i == frame_len - 1);
      pending_bytes.push_back(beat);
    end
  endtask

  // frame length that just holds the tunnel header and the fragment tag
  function automatic int tunnel_end(input int vlans, input int ihl_v);
    return 14 + 4 * vlans + 4 * ihl_v + PortBytes + stim_tun_hdr +
           ((stim_tag < MinTagBytes) ? int'(MinTagBytes) : stim_tag);
  endfunction

  // random bytes with the header fields laid on top; later writes win on overlap
  task automatic build_frame(input int vlans, input logic [15:0] etype,
                             input logic [3:0] ihl_v, input logic [7:0] proto,
                             input logic [3:0] doff, input logic [7:0] magic,
                             input logic msb, input int len);
    int l3, t, tun;
    fill_frame(len);
    l3  = 14 + 4 * vlans;
    t   = l3 + 4 * int'(ihl_v);
    tun = t + PortBytes;
    put_byte(tun + stim_nonce + 1, magic);
    put_byte(tun, {msb, frame_buf[tun][6:0]});
    put_byte(t + TcpOffPos, {doff, frame_buf[t + TcpOffPos][3:0]});
    put_byte(l3, {4'h4, ihl_v});
    put_byte(l3 + ProtoPos, proto);
    for (int v = 0; v < vlans; v++) begin
      put_byte(12 + 4 * v, EtherVlan[15:8]);
      put_byte(13 + 4 * v, EtherVlan[7:0]);
    end
    put_byte(12 + 4 * vlans, etype[15:8]);
    put_byte(13 + 4 * vlans, etype[7:0]);
    push_frame();
  endtask

  // mostly well-formed frames with random content, some noise and cut frames
  task automatic queue_random_frame();
    int         r, vl, ih, full, len;
    logic [15:0] et;
    logic [7:0] pr, mg;
    logic [3:0] dof;
    logic       msb;
    r = $urandom_range(99, 0);
    if (r < 10) begin
      fill_frame($urandom_range(40, 1));
      push_frame();
    end else begin
      vl  = ($urandom_range(99, 0) < 6) ? 3 : $urandom_range(2, 0);
      et  = ($urandom_range(99, 0) < 6) ? 16'($urandom) : EtherIpv4;
      ih  = ($urandom_range(99, 0) < 12) ? $urandom_range(4, 0) : $urandom_range(15, 5);
      r   = $urandom_range(99, 0);
      pr  = (r < 45) ? ProtoTcp : (r < 90) ? ProtoUdp : 8'($urandom);
      dof = ($urandom_range(99, 0) < 12) ? 4'($urandom_range(4, 0))
                                         : 4'($urandom_range(15, 5));
      r   = $urandom_range(99, 0);
      mg  = (r < 40) ? stim_data_magic : (r < 80) ? stim_frag_magic : 8'($urandom);
      msb = ($urandom_range(99, 0) < 25);
      full = tunnel_end(vl, ih);
      len  = ($urandom_range(99, 0) < 20) ? $urandom_range(full, 1)
                                          : full + $urandom_range(40, 0);
      build_frame(vl, et, 4'(ih), pr, dof, mg, msb, len);
    end
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int nonce, input int tun_hdr, input logic [7:0] dm,
                            input logic [7:0] fm, input int tag);
    write_reg(RegNonceBytes, 8'(nonce));
    write_reg(RegTunnelBytes, 8'(tun_hdr));
    write_reg(RegDataMagic, dm);
    write_reg(RegFragMagic, fm);
    write_reg(RegFragTagBytes, 8'(tag));
    stim_nonce      = nonce;
    stim_tun_hdr    = tun_hdr;
    stim_data_magic = dm;
    stim_frag_magic = fm;
    stim_tag        = tag;
  endtask

  // waits until every byte is sent and every owed result is in, then the block drains
  task automatic wait_idle();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || predicted_classes.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic run_random_phase(input int min_frames, input int min_bytes);
    int nf, nb;
    nf = 0;
    nb = 0;
    while (nf < min_frames || nb < min_bytes) begin
      queue_random_frame();
      nf++;
      nb += frame_len;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] dm, fm;
    int         tag;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames at the reset configuration, light idling
    idle_pct = 15;
    fill_frame(1);                                   // lone closing byte
    push_frame();
    for (int i = 0; i < 60; i++) frame_buf[i] = 8'h00;
    frame_len = 60;
    push_frame();
    for (int i = 0; i < 60; i++) frame_buf[i] = 8'hFF;
    push_frame();
    build_frame(0, 16'h86DD, 4'd5, ProtoUdp, 4'd5, 8'h00, 1'b0, 60);   // not ipv4
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, DataMagicReset, 1'b0,
                tunnel_end(0, 5));                                      // data tunnel
    build_frame(1, EtherIpv4, 4'd5, ProtoTcp, 4'd5, FragMagicReset, 1'b0,
                tunnel_end(1, 5) + 3);                                  // fragment tunnel
    build_frame(2, EtherIpv4, 4'd6, ProtoTcp, 4'd15, 8'h77, 1'b1, 120); // two tags
    build_frame(1, 16'h88A8, 4'd5, ProtoTcp, 4'd5, 8'h00, 1'b0, 64);   // tag, then not ipv4
    build_frame(3, EtherIpv4, 4'd5, ProtoTcp, 4'd5, 8'h00, 1'b0, 80);  // three tags
    build_frame(0, EtherIpv4, 4'd5, ProtoTcp, 4'd5, 8'h00, 1'b0, 33);  // truncated ip
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, 8'h00, 1'b0, 34);  // bare ip header
    build_frame(0, EtherIpv4, 4'd5, 8'd1, 4'd5, 8'h00, 1'b0, 64);      // not tcp/udp
    build_frame(0, EtherIpv4, 4'd4, ProtoTcp, 4'd5, 8'h00, 1'b0, 64);  // ihl too small
    build_frame(2, EtherIpv4, 4'd15, ProtoUdp, 4'd5, FragMagicReset, 1'b0,
                tunnel_end(2, 15));                                     // largest ihl
    build_frame(0, EtherIpv4, 4'd5, ProtoTcp, 4'd4, 8'h00, 1'b0, 80);  // tcp offset short
    build_frame(0, EtherIpv4, 4'd5, ProtoTcp, 4'd15, 8'h00, 1'b0, 60); // tcp past end
    build_frame(0, EtherIpv4, 4'd15, ProtoUdp, 4'd5, 8'h00, 1'b0, 34); // transport past end
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, 8'h00, 1'b0, 51);  // magic not received
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, 8'h00, 1'b0, 52);  // magic just in
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, 8'h00, 1'b1, 60);  // first msb set
    build_frame(0, EtherIpv4, 4'd5, ProtoTcp, 4'd5, FragMagicReset, 1'b0, 54); // tag cut
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, FragMagicReset, 1'b0,
                MaxFrameBytes + 7);                                     // counter saturates
    wait_idle();

    // smallest settings
    set_config(0, 2, 8'h00, 8'hFF, 3);
    idle_pct = 10;
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, 8'hFF, 1'b1, tunnel_end(0, 5));
    run_random_phase(10, 150);

    // largest settings
    set_config(16, 32, 8'hFF, 8'h00, 8);
    idle_pct = 30;
    run_random_phase(10, 150);

    // both magics equal and a fragment tag below the minimum
    set_config($urandom_range(16, 0), $urandom_range(32, 2), 8'h5A, 8'h5A, 2);
    idle_pct = 0;
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, 8'h5A, 1'b0, tunnel_end(0, 5));
    build_frame(0, EtherIpv4, 4'd5, ProtoUdp, 4'd5, 8'h5A, 1'b1, tunnel_end(0, 5));
    run_random_phase(8, 100);

    // long receiver hold-off while short frames keep coming: block backs up
    hold_armed = 1'b1;
    for (int i = 0; i < 40; i++) begin
      fill_frame($urandom_range(6, 1));
      push_frame();
    end
    wait_idle();

    // random settings, varied idling
    for (int ph = 0; ph < 4; ph++) begin
      dm  = 8'($urandom);
      fm  = ($urandom_range(99, 0) < 15) ? dm : 8'($urandom);
      tag = ($urandom_range(99, 0) < 10) ? $urandom_range(2, 0) : $urandom_range(8, 3);
      set_config($urandom_range(16, 0), $urandom_range(32, 2), dm, fm, tag);
      idle_pct = (ph == 0) ? 0 : 10 * ph;
      run_random_phase(10, 200);
    end

    // back to the reset values, no idling on either side
    set_config(NonceBytesReset, TunnelBytesReset, DataMagicReset, FragMagicReset,
               FragTagBytesReset);
    quiet = 1'b1;
    run_random_phase(10, 150);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: l4_tunnel_header_parser_unit.f
rtl/l4thp_pkg.sv
rtl/l4_tunnel_header_parser_unit.sv
rtl/l4thp_checker.sv
tb/l4_tunnel_header_parser_unit_tb.sv
